@@ rtl/matrix_multiply_core_defines.svh @@
// Assertion macros for the matrix multiply core checker
`ifndef MATRIX_MULTIPLY_CORE_DEFINES_SVH
`define MATRIX_MULTIPLY_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock, quiet during reset
`define MMC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, quiet during reset
`define MMC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/mmc_pkg.sv @@
// Shared constants, codes and control types of the matrix multiply core
package mmc_pkg;

   // Sizing
   localparam int MAX_DIM     = 8;
   localparam int FRAC_BITS   = 16;
   localparam int DIM_CAP     = (MAX_DIM < 8) ? MAX_DIM : 8;
   localparam int DATA_W      = 32;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int ACC_W       = PROD_W + $clog2(DIM_CAP) + 1;
   localparam int IDX_W       = 6;
   localparam int STORE_DEPTH = 1 << IDX_W;
   localparam int DIM_W       = 4;
   localparam int CSR_IDX_W   = 2;

   // Element operation codes
   localparam logic OP_LEFT  = 1'b0;
   localparam logic OP_RIGHT = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_DIM = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_OUT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_OUT  = 2'd2;

   // Reset value of every dimension register
   localparam logic [DIM_W-1:0] DIM_RESET = 4'd4;

   // Sequencer commands to the multiply-accumulate unit
   typedef struct packed {
      logic clear;
      logic mul_en;
      logic acc_en;
   } mac_ctrl_type;

endpackage

@@ rtl/mmc_store.sv @@
// Left and right matrix stores with one write port and registered reads
module mmc_store (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic                       wr_sel,
   input  logic [mmc_pkg::IDX_W-1:0]  wr_addr,
   input  logic [mmc_pkg::DATA_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [mmc_pkg::IDX_W-1:0]  left_addr,
   input  logic [mmc_pkg::IDX_W-1:0]  right_addr,
   output logic [mmc_pkg::DATA_W-1:0] left_data,
   output logic [mmc_pkg::DATA_W-1:0] right_data
);
   import mmc_pkg::*;

   logic [DATA_W-1:0] left_mem  [STORE_DEPTH];
   logic [DATA_W-1:0] right_mem [STORE_DEPTH];
   logic [DATA_W-1:0] left_data_ff;
   logic [DATA_W-1:0] right_data_ff;

   // Write the addressed element into the selected store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (wr_sel == OP_RIGHT) begin
            right_mem[wr_addr] <= wr_data;
         end else begin
            left_mem[wr_addr] <= wr_data;
         end
      end
   end

   // Read one operand pair
   always_ff @(posedge clock) begin
      if (rd_en) begin
         left_data_ff  <= left_mem[left_addr];
         right_data_ff <= right_mem[right_addr];
      end
   end

   assign left_data  = left_data_ff;
   assign right_data = right_data_ff;

endmodule

@@ rtl/mmc_mac.sv @@
// Shared multiply-accumulate unit with fixed-point shift and saturation
module mmc_mac (
   input  logic                              clock,
   input  mmc_pkg::mac_ctrl_type             ctrl,
   input  logic signed [mmc_pkg::DATA_W-1:0] operand_a,
   input  logic signed [mmc_pkg::DATA_W-1:0] operand_b,
   output logic signed [mmc_pkg::DATA_W-1:0] sat_value
);
   import mmc_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  shifted;
   logic [ACC_W-DATA_W:0]    upper;

   // Register the product before it reaches the adder
   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= operand_a * operand_b;
      end
   end

   // Clear or accumulate at full width
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.acc_en) begin
         acc_in = acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Floor shift, then saturate to the 32-bit range
   assign shifted = acc_ff >>> FRAC_BITS;
   assign upper   = shifted[ACC_W-1:DATA_W-1];

   always_comb begin
      if ((&upper) || !(|upper)) begin
         sat_value = shifted[DATA_W-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         sat_value = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sat_value = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

endmodule

@@ rtl/matrix_multiply_core.sv @@
// Top level of the matrix multiply core: registers, sequencer, stores and MAC unit
//
// Channel   Dir  Handshake              Payload
// req_      in   req_valid/req_ready    operation, element_index, element_value, start_multiply
// rsp_      out  rsp_valid/rsp_ready    product_value, product_index, last_result
// csr_      in   csr_valid/csr_ready    csr_index, csr_data (dimension registers)
//
// Element loads are accepted while the core is idle and written straight into the stores.
// After a start item each product element takes a fetch, multiply and accumulate step
// per inner term, m terms with m being inner_dim capped at 8, on the single shared
// MAC, and is then held until its rsp transfer.
// req_ready stays low from a start transfer with nonzero row and column counts until the final product transfer.
// Synchronous active-high reset restores all dimensions to 4; stores are not cleared.
module matrix_multiply_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic [mmc_pkg::IDX_W-1:0]           req_element_index,
   input  logic signed [mmc_pkg::DATA_W-1:0]   req_element_value,
   input  logic                                req_start_multiply,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [mmc_pkg::DATA_W-1:0]   rsp_product_value,
   output logic [mmc_pkg::IDX_W-1:0]           rsp_product_index,
   output logic                                rsp_last_result,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mmc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mmc_pkg::DIM_W-1:0]           csr_data
);
   import mmc_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_FETCH = 6'b000010,
      ST_MULT  = 6'b000100,
      ST_ACCUM = 6'b001000,
      ST_EMIT  = 6'b010000,
      ST_WAIT  = 6'b100000
   } state_type;

   function automatic logic [DIM_W-1:0] cap_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] cap;
      cap = DIM_W'(DIM_CAP);
      return (d > cap) ? cap : d;
   endfunction

   state_type          state_ff, state_in;
   logic [DIM_W-1:0]   inner_ff, rows_ff, cols_ff;
   logic [DIM_W-1:0]   row_ff, row_in, col_ff, col_in, k_ff, k_in;
   logic [IDX_W-1:0]   lbase_ff, lbase_in, rptr_ff, rptr_in, count_ff, count_in;
   logic [DATA_W-1:0]  value_ff;
   logic [IDX_W-1:0]   index_ff;
   logic               last_ff;
   logic [DIM_W-1:0]   dim_m, dim_n, dim_p;
   logic               req_xfer, rsp_xfer, is_last;
   logic [DIM_W-1:0]   k_next;
   logic [IDX_W-1:0]   left_addr;
   logic [DATA_W-1:0]  left_data, right_data;
   logic signed [DATA_W-1:0] sat_value;
   mac_ctrl_type       mac_ctrl;

   assign dim_m = cap_dim(inner_ff);
   assign dim_n = cap_dim(rows_ff);
   assign dim_p = cap_dim(cols_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_WAIT);
   assign csr_ready = 1'b1;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid && rsp_ready;

   assign is_last   = (row_ff == dim_n - DIM_W'(1)) && (col_ff == dim_p - DIM_W'(1));
   assign k_next    = k_ff + DIM_W'(1);
   assign left_addr = lbase_ff + IDX_W'(k_ff);

   // Dimension registers
   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff <= DIM_RESET;
         rows_ff  <= DIM_RESET;
         cols_ff  <= DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_INNER_DIM: inner_ff <= csr_data;
            CSR_ROWS_OUT:  rows_ff  <= csr_data;
            CSR_COLS_OUT:  cols_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Sequencer: walk rows, columns and the inner sum
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      k_in     = k_ff;
      lbase_in = lbase_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      mac_ctrl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_start_multiply &&
                dim_n != '0 && dim_p != '0) begin
               row_in         = '0;
               col_in         = '0;
               k_in           = '0;
               lbase_in       = '0;
               rptr_in        = '0;
               count_in       = '0;
               mac_ctrl.clear = 1'b1;
               state_in       = (dim_m == '0) ? ST_EMIT : ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_MULT;
         end
         ST_MULT: begin
            mac_ctrl.mul_en = 1'b1;
            state_in        = ST_ACCUM;
         end
         ST_ACCUM: begin
            mac_ctrl.acc_en = 1'b1;
            k_in            = k_next;
            rptr_in         = rptr_ff + IDX_W'(dim_p);
            state_in        = (k_next == dim_m) ? ST_EMIT : ST_FETCH;
         end
         ST_EMIT: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (rsp_xfer) begin
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  count_in       = count_ff + IDX_W'(1);
                  k_in           = '0;
                  mac_ctrl.clear = 1'b1;
                  if (col_ff == dim_p - DIM_W'(1)) begin
                     col_in   = '0;
                     row_in   = row_ff + DIM_W'(1);
                     lbase_in = lbase_ff + IDX_W'(dim_m);
                  end else begin
                     col_in = col_ff + DIM_W'(1);
                  end
                  rptr_in  = IDX_W'(col_in);
                  state_in = (dim_m == '0) ? ST_EMIT : ST_FETCH;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Loop counters and address pointers
   always_ff @(posedge clock) begin
      row_ff   <= row_in;
      col_ff   <= col_in;
      k_ff     <= k_in;
      lbase_ff <= lbase_in;
      rptr_ff  <= rptr_in;
      count_ff <= count_in;
   end

   // Hold the product element for the rsp transfer
   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT) begin
         value_ff <= sat_value;
         index_ff <= count_ff;
         last_ff  <= is_last;
      end
   end

   assign rsp_product_value = value_ff;
   assign rsp_product_index = index_ff;
   assign rsp_last_result   = last_ff;

   mmc_store u_store (
      .clock      (clock),
      .wr_en      (req_xfer),
      .wr_sel     (req_operation),
      .wr_addr    (req_element_index),
      .wr_data    (req_element_value),
      .rd_en      (state_ff == ST_FETCH),
      .left_addr  (left_addr),
      .right_addr (rptr_ff),
      .left_data  (left_data),
      .right_data (right_data)
   );

   mmc_mac u_mac (
      .clock     (clock),
      .ctrl      (mac_ctrl),
      .operand_a (left_data),
      .operand_b (right_data),
      .sat_value (sat_value)
   );

endmodule

@@ rtl/mmc_checker.sv @@
// Port-level checker for the matrix multiply core and its bind
`include "matrix_multiply_core_defines.svh"

module mmc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [mmc_pkg::DATA_W-1:0] rsp_product_value,
   input logic [mmc_pkg::IDX_W-1:0]         rsp_product_index,
   input logic                              rsp_last_result
);
   import mmc_pkg::*;

   // No new elements while a product element is on offer
   `MMC_ASSERT_SAME(a_busy_while_rsp, rsp_valid, !req_ready, "req_ready high with rsp pending")

   // The final transfer hands the core back to the loader
   `MMC_ASSERT_NEXT(a_idle_after_last, rsp_valid && rsp_ready && rsp_last_result,
                    req_ready, "not ready after final product")

   // More product elements follow an intermediate transfer
   `MMC_ASSERT_NEXT(a_busy_mid_run, rsp_valid && rsp_ready && !rsp_last_result,
                    !req_ready && !rsp_valid, "run ended early")

   // A stalled product element holds
   `MMC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_product_value) &&
                    $stable(rsp_product_index) && $stable(rsp_last_result),
                    "stalled rsp changed")

endmodule

bind matrix_multiply_core mmc_checker u_mmc_checker (.*);
